@@ design/nearest_neighbor_audio_resampler_unit_defines.svh @@
// Assertion macros shared by the resampler RTL.
`ifndef NEAREST_NEIGHBOR_AUDIO_RESAMPLER_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_AUDIO_RESAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NNAR_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NNAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nnar_pkg.sv @@
// Types and constants of the nearest-neighbor audio resampler.
`timescale 1ns / 1ps

package nnar_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 18;
  localparam int FC_W      = 24;
  localparam int PHASE_W   = 48;
  localparam int DIG_W     = 8;
  localparam int NDIG      = PHASE_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(NDIG);
  localparam int MUL_CNT_W = $clog2(RATE_W + 1);
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SRC_RATE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DST_RATE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEREO      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 2'd3;

  localparam logic [RATE_W-1:0] SRC_RATE_RST = 18'd48000;
  localparam logic [RATE_W-1:0] DST_RATE_RST = 18'd48000;

  // Commands from the sequencer to the phase datapath.
  typedef struct packed {
    logic clear;       // new buffer: zero both phases
    logic mul_start;   // recompute the output-count limit
    logic pass_start;  // arm carries and compare flags for a new pass
    logic shift;       // process one digit
    logic commit_out;  // out_phase takes the incremented phase
    logic commit_in;   // in_phase takes the frame end
  } dp_ctl_t;

  // Results of a finished pass.
  typedef struct packed {
    logic gt_a;      // 2*out_phase + src > limit
    logic ge_b;      // out_phase >= in_phase + dst
    logic gt_l;      // 2*(out_phase + src) + src > limit
    logic mul_busy;
  } dp_sts_t;

endpackage

@@ design/nnar_in_if.sv @@
// Input channel: one stereo or mono frame per word.
`timescale 1ns / 1ps

interface nnar_in_if import nnar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;

  modport source (output valid, in_left, in_right, input ready);
  modport sink (input valid, in_left, in_right, output ready);
endinterface

@@ design/nnar_out_if.sv @@
// Result channel: one resampled frame per word.
`timescale 1ns / 1ps

interface nnar_out_if import nnar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       last_frame;

  modport source (output valid, out_left, out_right, last_frame, input ready);
  modport sink (input valid, out_left, out_right, last_frame, output ready);
endinterface

@@ design/nnar_phase_dp.sv @@
// Digit-serial phase datapath: phase accumulators, comparisons and limit multiplier.
`timescale 1ns / 1ps

module nnar_phase_dp import nnar_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  input  logic [RATE_W-1:0] src_rate,
  input  logic [RATE_W-1:0] dst_rate,
  input  logic [FC_W-1:0]   frame_count,
  output dp_sts_t           sts
);

  logic [PHASE_W-1:0]   op_r, ip_r, lim_r, nxt_r, fe_r, src_sh_r, dst_sh_r;
  logic                 c1_r, c2_r, c3_r, c4_r;
  logic                 op_msb_r, n_msb_r;
  logic                 gt_a_r, ge_b_r, gt_l_r;
  logic [RATE_W-1:0]    mul_sh_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic                 mul_busy_r;

  logic [DIG_W-1:0] d, sd, dd, ld, ipd, dbl_op, dbl_n;
  logic [DIG_W:0]   t1, n, t2, f;
  logic [PHASE_W-1:0] fc2;

  always_comb begin
    d      = op_r[DIG_W-1:0];
    ipd    = ip_r[DIG_W-1:0];
    ld     = lim_r[DIG_W-1:0];
    sd     = src_sh_r[DIG_W-1:0];
    dd     = dst_sh_r[DIG_W-1:0];
    // Doubling is a one-bit shift carried between digits.
    dbl_op = {d[DIG_W-2:0], op_msb_r};
    t1     = {1'b0, dbl_op} + {1'b0, sd} + {{DIG_W{1'b0}}, c1_r};
    n      = {1'b0, d} + {1'b0, sd} + {{DIG_W{1'b0}}, c2_r};
    dbl_n  = {n[DIG_W-2:0], n_msb_r};
    t2     = {1'b0, dbl_n} + {1'b0, sd} + {{DIG_W{1'b0}}, c3_r};
    f      = {1'b0, ipd} + {1'b0, dd} + {{DIG_W{1'b0}}, c4_r};
    fc2    = {{(PHASE_W-FC_W-1){1'b0}}, frame_count, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= '0;
      ip_r       <= '0;
      lim_r      <= '0;
      mul_cnt_r  <= '0;
      mul_busy_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        op_r <= '0;
        ip_r <= '0;
      end else if (ctl.shift) begin
        op_r <= {d, op_r[PHASE_W-1:DIG_W]};
        ip_r <= {ipd, ip_r[PHASE_W-1:DIG_W]};
      end else begin
        if (ctl.commit_out) op_r <= nxt_r;
        if (ctl.commit_in) ip_r <= fe_r;
      end

      // Limit 2*frame_count*dst_rate, one multiplier bit per cycle, MSB first.
      if (ctl.mul_start) begin
        lim_r      <= '0;
        mul_cnt_r  <= MUL_CNT_W'(RATE_W);
        mul_busy_r <= 1'b1;
      end else if (mul_busy_r) begin
        lim_r     <= {lim_r[PHASE_W-2:0], 1'b0} + (mul_sh_r[RATE_W-1] ? fc2 : '0);
        mul_cnt_r <= mul_cnt_r - MUL_CNT_W'(1);
        if (mul_cnt_r == MUL_CNT_W'(1)) mul_busy_r <= 1'b0;
      end else if (ctl.shift) begin
        lim_r <= {ld, lim_r[PHASE_W-1:DIG_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_start) begin
      mul_sh_r <= dst_rate;
    end else if (mul_busy_r) begin
      mul_sh_r <= {mul_sh_r[RATE_W-2:0], 1'b0};
    end

    if (ctl.pass_start) begin
      src_sh_r <= {{(PHASE_W-RATE_W){1'b0}}, src_rate};
      dst_sh_r <= {{(PHASE_W-RATE_W){1'b0}}, dst_rate};
      c1_r     <= 1'b0;
      c2_r     <= 1'b0;
      c3_r     <= 1'b0;
      c4_r     <= 1'b0;
      op_msb_r <= 1'b0;
      n_msb_r  <= 1'b0;
      gt_a_r   <= 1'b0;
      gt_l_r   <= 1'b0;
      ge_b_r   <= 1'b1;
    end else if (ctl.shift) begin
      src_sh_r <= {{DIG_W{1'b0}}, src_sh_r[PHASE_W-1:DIG_W]};
      dst_sh_r <= {{DIG_W{1'b0}}, dst_sh_r[PHASE_W-1:DIG_W]};
      nxt_r    <= {n[DIG_W-1:0], nxt_r[PHASE_W-1:DIG_W]};
      fe_r     <= {f[DIG_W-1:0], fe_r[PHASE_W-1:DIG_W]};
      c1_r     <= t1[DIG_W];
      c2_r     <= n[DIG_W];
      c3_r     <= t2[DIG_W];
      c4_r     <= f[DIG_W];
      op_msb_r <= d[DIG_W-1];
      n_msb_r  <= n[DIG_W-1];
      // Digits arrive LSB first, so a differing digit overrides the verdict so far.
      gt_a_r   <= (t1[DIG_W-1:0] > ld) | ((t1[DIG_W-1:0] == ld) & gt_a_r);
      gt_l_r   <= (t2[DIG_W-1:0] > ld) | ((t2[DIG_W-1:0] == ld) & gt_l_r);
      ge_b_r   <= (d > f[DIG_W-1:0]) | ((d == f[DIG_W-1:0]) & ge_b_r);
    end
  end

  assign sts.gt_a     = gt_a_r;
  assign sts.ge_b     = ge_b_r;
  assign sts.gt_l     = gt_l_r;
  assign sts.mul_busy = mul_busy_r;

endmodule

@@ design/nearest_neighbor_audio_resampler_unit.sv @@
// Top level of the nearest-neighbor audio resampler.
//
//   port group   | direction | word
//   -------------+-----------+-------------------------------------------
//   in_ch        | sink      | in_left, in_right (one input frame)
//   out_ch       | source    | out_left, out_right, last_frame
//   APB (p*)     | slave     | src_rate, dst_rate, stereo, frame_count
//
// Each candidate output takes one pass through the 48-bit phases, 8 bits a cycle,
// then a decision state; an input word giving n outputs runs n+1 passes at most
// (n when the last output or the per-frame cap ends it), and a decision that
// emits a word waits while the output register is full. A register write holds
// off input words while the bit-serial multiply of the output-count limit is
// launched and run. rst_n is synchronous, active low. The output register lets
// the next input word be taken while a word waits.
`timescale 1ns / 1ps
`include "nearest_neighbor_audio_resampler_unit_defines.svh"

module nearest_neighbor_audio_resampler_unit import nnar_pkg::*; #(
  parameter int MAX_UPSAMPLE = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  nnar_in_if.sink            in_ch,
  nnar_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PASS   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [RATE_W-1:0]    src_r, dst_r;
  logic                 stereo_r;
  logic [FC_W-1:0]      fc_r;
  logic [FC_W-1:0]      frames_seen_r;
  logic                 done_r, have_r, mul_go_r;
  logic [CNT_W-1:0]     cnt_r, cnt_inc;
  logic [DIG_CNT_W-1:0] dig_r;
  logic [SAMPLE_W-1:0]  left_r, right_r;
  logic                 out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0]  out_left_r, out_right_r;

  logic                 cfg_wr, in_acc, have, rates_ok, emit, slot_free, more;
  logic [REG_IDX_W-1:0] reg_idx;
  dp_ctl_t              ctl;
  dp_sts_t              sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_SRC_RATE:    prdata = {{(PDATA_W-RATE_W){1'b0}}, src_r};
      REG_DST_RATE:    prdata = {{(PDATA_W-RATE_W){1'b0}}, dst_r};
      REG_STEREO:      prdata = {{(PDATA_W-1){1'b0}}, stereo_r};
      REG_FRAME_COUNT: prdata = {{(PDATA_W-FC_W){1'b0}}, fc_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r    <= SRC_RATE_RST;
      dst_r    <= DST_RATE_RST;
      stereo_r <= 1'b0;
      fc_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_RATE:    src_r    <= pwdata[RATE_W-1:0];
        REG_DST_RATE:    dst_r    <= pwdata[RATE_W-1:0];
        REG_STEREO:      stereo_r <= pwdata[0];
        REG_FRAME_COUNT: fc_r     <= pwdata[FC_W-1:0];
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) & ~sts.mul_busy & ~mul_go_r;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign have        = frames_seen_r < fc_r;
  assign rates_ok    = (src_r != '0) & (dst_r != '0);
  assign slot_free   = ~out_valid_r | out_ch.ready;
  assign emit        = ~done_r & rates_ok & ~sts.gt_a & ~(have_r & sts.ge_b);
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign more        = emit & ~sts.gt_l & (cnt_inc != CNT_W'(MAX_UPSAMPLE));

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.clear      = cfg_wr;
    ctl.mul_start  = mul_go_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.pass_start = 1'b1;
          state_nxt      = S_PASS;
        end
      end
      S_PASS: begin
        ctl.shift = 1'b1;
        if (dig_r == DIG_CNT_W'(NDIG - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!emit || slot_free) begin
          ctl.commit_out = emit;
          if (more) begin
            ctl.pass_start = 1'b1;
            state_nxt      = S_PASS;
          end else begin
            ctl.commit_in = have_r;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      frames_seen_r <= '0;
      done_r        <= 1'b0;
      mul_go_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      dig_r         <= '0;
      cnt_r         <= '0;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= cfg_wr;

      if (ctl.pass_start) dig_r <= '0;
      else if (ctl.shift) dig_r <= dig_r + DIG_CNT_W'(1);

      if (in_acc) cnt_r <= '0;
      else if (ctl.commit_out) cnt_r <= cnt_inc;

      if (cfg_wr) begin
        frames_seen_r <= '0;
        done_r        <= 1'b0;
      end else begin
        if (ctl.commit_in) frames_seen_r <= frames_seen_r + FC_W'(1);
        if (ctl.commit_out && sts.gt_l) done_r <= 1'b1;
      end

      if (ctl.commit_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      have_r  <= have;
      left_r  <= have ? in_ch.in_left : '0;
      right_r <= (have && stereo_r) ? in_ch.in_right : '0;
    end
    if (ctl.commit_out) begin
      out_left_r  <= left_r;
      out_right_r <= right_r;
      out_last_r  <= sts.gt_l;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_left   = out_left_r;
  assign out_ch.out_right  = out_right_r;
  assign out_ch.last_frame = out_last_r;

  nnar_phase_dp u_phase_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .src_rate    (src_r),
    .dst_rate    (dst_r),
    .frame_count (fc_r),
    .sts         (sts)
  );

  `NNAR_ASSERT_HOLDS(a_word_from_decide, $rose(out_valid_r), $past(state_r) == S_DECIDE, "output word loaded outside the decision cycle")
  `NNAR_ASSERT_NEXT(a_no_word_after_last, done_r, !$rose(out_valid_r), "output word produced after the last frame")
  `NNAR_ASSERT_HOLDS(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_UPSAMPLE), "per-frame output count exceeds the cap")
  `NNAR_ASSERT_HOLDS(a_frames_bound, 1'b1, frames_seen_r <= fc_r, "frames consumed exceed the buffer length")

endmodule

@@ tb/sv/nearest_neighbor_audio_resampler_unit_tb.sv @@
// Self-checking testbench for the nearest-neighbor audio resampler unit.
`timescale 1ns / 1ps

module nearest_neighbor_audio_resampler_unit_tb;
  import nnar_pkg::*;

  localparam int PER_FRAME_CAP  = 63;
  localparam int DRAIN_CYCLES   = 500;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 320;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [FC_W-1:0]   FC_MAX   = '1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    last;
  } out_frame_t;

  typedef enum {ROW_WRITE, ROW_FRAME} row_kind_t;
  typedef enum {EXPECT_PREDICTED, EXPECT_NOTHING, EXPECT_TYPED} row_check_t;
  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  typedef struct {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [PDATA_W-1:0]     value;
    sample_t                left;
    sample_t                right;
    row_check_t             check;
    out_frame_t             typed;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nnar_in_if  in_ch ();
  nnar_out_if out_ch ();

  nearest_neighbor_audio_resampler_unit #(
    .MAX_UPSAMPLE(PER_FRAME_CAP)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and buffer state of the resampler.
  logic [RATE_W-1:0]  src_hz     = SRC_RATE_RST;
  logic [RATE_W-1:0]  dst_hz     = DST_RATE_RST;
  logic               stereo_on  = 1'b0;
  logic [FC_W-1:0]    buf_frames = '0;
  logic [PHASE_W-1:0] out_pos;
  logic [PHASE_W-1:0] in_pos;
  logic [FC_W-1:0]    frames_taken;
  logic               buf_done;

  out_frame_t step_frames [PER_FRAME_CAP];
  out_frame_t expected_frames [$];
  stim_row_t  stim_rows [$];
  int         fail_count  = 0;
  int         idle_cycles = 0;
  int         burst_left  = 0;

  function automatic void clear_buffer();
    out_pos      = '0;
    in_pos       = '0;
    frames_taken = '0;
    buf_done     = 1'b0;
  endfunction

  function automatic void apply_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
    case (idx)
      REG_SRC_RATE:    src_hz = data[RATE_W-1:0];
      REG_DST_RATE:    dst_hz = data[RATE_W-1:0];
      REG_STEREO:      stereo_on = data[0];
      REG_FRAME_COUNT: buf_frames = data[FC_W-1:0];
      default:         return;
    endcase
    clear_buffer();
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SRC_RATE:    return PDATA_W'(src_hz);
      REG_DST_RATE:    return PDATA_W'(dst_hz);
      REG_STEREO:      return PDATA_W'(stereo_on);
      default:         return PDATA_W'(buf_frames);
    endcase
  endfunction

  // Fills step_frames with the output words caused by one input frame and
  // returns how many there are. Phases compare i*src against k*dst, so the
  // frame index and the rounded output count come out without a division.
  function automatic int resample_frame(sample_t l, sample_t r);
    longint unsigned src64, dst64, lim2, frame_end, pos, nxt;
    logic            have, fin, go;
    sample_t         dl, dr;
    int              n;
    src64     = 64'(src_hz);
    dst64     = 64'(dst_hz);
    lim2      = 64'(buf_frames);
    lim2      = 2 * lim2 * dst64;
    have      = frames_taken < buf_frames;
    dl        = have ? l : '0;
    dr        = (have && stereo_on) ? r : '0;
    frame_end = 64'(in_pos);
    frame_end = frame_end + dst64;
    pos       = 64'(out_pos);
    n         = 0;
    go        = !buf_done && src64 != 0 && dst64 != 0;
    while (go && n < PER_FRAME_CAP) begin
      if ((2 * pos + src64 > lim2) || (have && pos >= frame_end)) begin
        go = 1'b0;
      end else begin
        nxt = pos + src64;
        fin = (2 * nxt + src64) > lim2;
        step_frames[n] = '{dl, dr, fin};
        pos = 64'(nxt[PHASE_W-1:0]);
        n++;
        if (fin) begin
          buf_done = 1'b1;
          go = 1'b0;
        end
      end
    end
    out_pos = pos[PHASE_W-1:0];
    if (have) begin
      frames_taken = frames_taken + 1'b1;
      in_pos = frame_end[PHASE_W-1:0];
    end
    return n;
  endfunction

  function automatic void add_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_WRITE, idx, data, '0, '0, EXPECT_PREDICTED, '{'0, '0, 1'b0}};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_frame(sample_t l, sample_t r, row_check_t chk,
                                    sample_t el, sample_t er, logic elast);
    stim_row_t row;
    row = '{ROW_FRAME, '0, '0, l, r, chk, '{el, er, elast}};
    stim_rows.push_back(row);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // APB transfers leave psel high; apb_release closes a run of them.
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_write(idx, data);
  endtask

  task automatic apb_read_check(logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $display("%0t: register %0d read expected %0h, got %0h",
               $time, idx, reg_value(idx), prdata);
      fail_count++;
    end
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(sample_t l, sample_t r, output int n);
    in_ch.valid    <= 1'b1;
    in_ch.in_left  <= l;
    in_ch.in_right <= r;
    do @(posedge clk); while (!in_ch.ready);
    n = resample_frame(l, r);
  endtask

  // Sender runs in bursts; a zero gap keeps valid high into the next burst.
  task automatic input_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic random_settings();
    logic [RATE_W-1:0] s, d;
    logic [FC_W-1:0]   fc;
    int unsigned       wide;
    d = RATE_W'($urandom_range(1, RATE_MAX));
    case ($urandom_range(0, 4))
      0: s = d;
      1: begin
        s = RATE_W'(d / $urandom_range(1, 100));
        if (s == 0) s = 1;
      end
      2: begin
        wide = d * $urandom_range(1, 8);
        s = (wide > RATE_MAX) ? RATE_MAX : wide[RATE_W-1:0];
      end
      3: s = RATE_W'($urandom_range(1, RATE_MAX));
      default: begin
        s = RATE_W'($urandom_range(1, 16));
        d = RATE_W'($urandom_range(1, 16));
      end
    endcase
    if ($urandom_range(0, 15) == 0) s = RATE_MAX;
    if ($urandom_range(0, 15) == 0) d = RATE_MAX;
    case ($urandom_range(0, 19))
      0:       fc = '0;
      1:       fc = FC_MAX;
      2:       fc = FC_W'($urandom_range(0, FC_MAX));
      default: fc = FC_W'($urandom_range(1, 40));
    endcase
    if ($urandom_range(0, 3) != 0) apb_write(REG_SRC_RATE, PDATA_W'(s));
    if ($urandom_range(0, 3) != 0) apb_write(REG_DST_RATE, PDATA_W'(d));
    if ($urandom_range(0, 3) != 0) apb_write(REG_STEREO, PDATA_W'($urandom_range(0, 1)));
    // Writing the frame count always starts a fresh buffer.
    apb_write(REG_FRAME_COUNT, PDATA_W'(fc));
    apb_read_check(REG_SRC_RATE);
    apb_read_check(REG_DST_RATE);
    apb_read_check(REG_STEREO);
    apb_read_check(REG_FRAME_COUNT);
    apb_release();
  endtask

  // Receiver stalls follow a mode that is redrawn at random when its run ends.
  initial begin
    ready_mode_t mode;
    int          mode_left;
    out_ch.ready <= 1'b0;
    mode = RDY_ALWAYS;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (mode)
        RDY_ALWAYS: out_ch.ready <= 1'b1;
        RDY_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    out_ch.ready <= (mode_left % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected word left=%0d right=%0d last=%0b",
                 $time, out_ch.out_left, out_ch.out_right, out_ch.last_frame);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.out_left !== want.left) begin
          $display("%0t: out_left expected %0d, got %0d", $time, want.left, out_ch.out_left);
          fail_count++;
        end
        if (out_ch.out_right !== want.right) begin
          $display("%0t: out_right expected %0d, got %0d", $time, want.right, out_ch.out_right);
          fail_count++;
        end
        if (out_ch.last_frame !== want.last) begin
          $display("%0t: last_frame expected %0b, got %0b", $time, want.last,
                   out_ch.last_frame);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          done_items;
    int          frames;
    logic [FC_W-1:0] taken_before;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_left  <= '0;
    in_ch.in_right <= '0;
    clear_buffer();

    // Empty buffer after reset, then a 1:1 stereo buffer of two frames.
    add_frame(16'sh7fff, 16'sh8000, EXPECT_NOTHING, '0, '0, 1'b0);
    add_write(REG_STEREO, 1);
    add_write(REG_FRAME_COUNT, 2);
    add_frame(16'sh7fff, 16'sh8000, EXPECT_TYPED, 16'sh7fff, 16'sh8000, 1'b0);
    add_frame(16'sh8000, 16'sh7fff, EXPECT_TYPED, 16'sh8000, 16'sh7fff, 1'b1);
    add_frame(16'sd100, 16'sd200, EXPECT_NOTHING, '0, '0, 1'b0);
    // Mono zeroes the right channel.
    add_write(REG_STEREO, 0);
    add_frame(16'sh1234, 16'sh5678, EXPECT_TYPED, 16'sh1234, '0, 1'b0);
    add_frame(16'shffff, 16'shffff, EXPECT_TYPED, 16'shffff, '0, 1'b1);
    // Either rate at zero gives nothing.
    add_write(REG_SRC_RATE, 0);
    add_frame(16'sd5, 16'sd5, EXPECT_NOTHING, '0, '0, 1'b0);
    add_write(REG_SRC_RATE, 48000);
    add_write(REG_DST_RATE, 0);
    add_frame(16'sd5, 16'sd5, EXPECT_NOTHING, '0, '0, 1'b0);
    // Ratio of 100 overflows the per-frame cap; the overflow spills into
    // later calls, past the end of the buffer as zero samples.
    add_write(REG_SRC_RATE, 1);
    add_write(REG_DST_RATE, 100);
    add_write(REG_STEREO, 1);
    add_frame(16'sh0f0f, 16'shf0f0, EXPECT_PREDICTED, '0, '0, 1'b0);
    add_frame(16'sh5555, 16'shaaaa, EXPECT_PREDICTED, '0, '0, 1'b0);
    add_frame(16'sh3333, 16'shcccc, EXPECT_PREDICTED, '0, '0, 1'b0);
    add_frame(16'sh0001, 16'sh8001, EXPECT_PREDICTED, '0, '0, 1'b0);
    // Extreme downsampling on the largest buffer.
    add_write(REG_SRC_RATE, RATE_MAX);
    add_write(REG_DST_RATE, 1);
    add_write(REG_FRAME_COUNT, FC_MAX);
    add_frame(16'sh8000, 16'sh8000, EXPECT_TYPED, 16'sh8000, 16'sh8000, 1'b0);
    add_frame(16'sh7fff, 16'sh7fff, EXPECT_NOTHING, '0, '0, 1'b0);
    // Extreme upsampling of a single frame.
    add_write(REG_SRC_RATE, 1);
    add_write(REG_DST_RATE, RATE_MAX);
    add_write(REG_FRAME_COUNT, 1);
    add_frame(16'sh2468, 16'sh9753, EXPECT_PREDICTED, '0, '0, 1'b0);
    // Three frames at half rate round up to two outputs.
    add_write(REG_SRC_RATE, 2);
    add_write(REG_DST_RATE, 1);
    add_write(REG_FRAME_COUNT, 3);
    add_frame(16'sh0100, 16'sh0200, EXPECT_PREDICTED, '0, '0, 1'b0);
    add_frame(16'sh0300, 16'sh0400, EXPECT_PREDICTED, '0, '0, 1'b0);
    add_frame(16'sh0500, 16'sh0600, EXPECT_PREDICTED, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_WRITE) settle_block();
        apb_write(stim_rows[i].reg_idx, stim_rows[i].value);
        if (i + 1 == stim_rows.size() || stim_rows[i+1].kind != ROW_WRITE) apb_release();
      end else begin
        send_frame(stim_rows[i].left, stim_rows[i].right, n);
        case (stim_rows[i].check)
          EXPECT_PREDICTED: for (int k = 0; k < n; k++) expected_frames.push_back(step_frames[k]);
          EXPECT_TYPED:     expected_frames.push_back(stim_rows[i].typed);
          default:          ;
        endcase
        input_pace();
      end
    end

    // Frames the block only ignores are not counted as stimulus.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      settle_block();
      random_settings();
      frames = (buf_frames <= 40) ? buf_frames + $urandom_range(0, 3) : $urandom_range(8, 40);
      repeat (frames) begin
        taken_before = frames_taken;
        send_frame(pick_sample(), pick_sample(), n);
        for (int k = 0; k < n; k++) expected_frames.push_back(step_frames[k]);
        if (n > 0 || frames_taken != taken_before) done_items++;
        input_pace();
      end
    end

    settle_block();
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/nnar_pkg.sv
design/nnar_in_if.sv
design/nnar_out_if.sv
design/nnar_phase_dp.sv
design/nearest_neighbor_audio_resampler_unit.sv
tb/sv/nearest_neighbor_audio_resampler_unit_tb.sv
